@@ rtl/core/efh_pkg.sv @@
package efh_pkg;

	localparam int unsigned BUCKETS_DEF = 4096;
	localparam int unsigned POOL_DEF    = 4096;
	localparam int unsigned PT_W        = 24;
	localparam int unsigned MAT_W       = 8;
	localparam int unsigned KEY_W       = 2 * PT_W + MAT_W;
	localparam int unsigned CFG_W       = 13;
	localparam int unsigned IDX_W       = 12;
	localparam int unsigned ST_W        = 2;
	localparam logic [12:0] NB_RESET    = 13'd4096;

	localparam logic [31:0] K_MAT = 32'd521;
	localparam logic [31:0] K_LO  = 32'd18457;
	localparam logic [31:0] K_HI  = 32'd234749;

	localparam logic [ST_W-1:0] ST_FOUND    = 2'd0;
	localparam logic [ST_W-1:0] ST_INSERTED = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MUL  = 9'b000000010,
		S_SUM  = 9'b000000100,
		S_DIV  = 9'b000001000,
		S_HEAD = 9'b000010000,
		S_WAIT = 9'b000100000,
		S_CMP  = 9'b001000000,
		S_INS  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

endpackage

@@ rtl/core/edge_find_or_insert_hash.sv @@
// Edge find-or-insert table. Each input word carries two point ids and a
// material; the key is the ordered pair plus material. The block hashes the
// key, reduces it by num_buckets with a bit-serial remainder unit, then
// walks the bucket chain in on-chip memory: it fetches the chain head, then
// for each chain link reads the entry (registered read) and compares the key.
// A hit raises the result word directly; a miss, or a full pool, first goes
// through the insert step. The block is ready for the next input word in the
// same cycle that the result word is raised. A result word is held in its own
// register until taken while the block goes on with the next item, which then
// waits in its last step until that register is free; one item is in flight at
// a time. After reset a clearing pass writes the empty marker into every bucket
// head, one per cycle, during which no input word is accepted. Status is 0
// found, 1 inserted, 2 pool full (index 0, nothing changes).
module edge_find_or_insert_hash #(
	parameter int unsigned BUCKETS      = efh_pkg::BUCKETS_DEF,
	parameter int unsigned POOL_ENTRIES = efh_pkg::POOL_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// cfg: num_buckets [12:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// point_a [23:0], point_b [47:24], material [55:48]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// entry_index [11:0], status [13:12]
	output logic [15:0] m_tdata
);
	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int unsigned LW = PW + 1; // link with null marker
	localparam int unsigned CW = $clog2(POOL_ENTRIES + 1);
	localparam int unsigned NW = $clog2(BUCKETS + 1);
	localparam logic [LW-1:0] NIL = {LW{1'b1}};
	localparam logic [CW-1:0] POOL_FULL = CW'(POOL_ENTRIES);

	logic [LW-1:0] heads_mem [BUCKETS];
	logic [efh_pkg::KEY_W-1:0] keys_mem [POOL_ENTRIES];
	logic [LW-1:0] links_mem [POOL_ENTRIES];

	efh_pkg::state_t state_q;
	logic [12:0] nb_q;
	logic [CW-1:0] used_q;
	logic clr_q;
	logic [BW-1:0] clr_idx_q;
	logic [23:0] lo_q, hi_q;
	logic [7:0] mat_q;
	logic [31:0] pm_q, pl_q, ph_q, mag_q;
	logic neg_q;
	logic [NW-1:0] n_q;
	logic [NW:0] rem_q;
	logic [5:0] bit_q;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] cur_q, head_rd_q, link_rd_q;
	logic [efh_pkg::KEY_W-1:0] key_rd_q;
	logic [CW:0] steps_q;
	logic out_v_q;
	logic [efh_pkg::IDX_W-1:0] out_idx_q;
	logic [efh_pkg::ST_W-1:0] out_st_q;
	logic [efh_pkg::IDX_W-1:0] res_idx_q;
	logic [efh_pkg::ST_W-1:0] res_st_q;

	logic [23:0] pa, pb;
	logic [31:0] h_sum;
	logic [NW-1:0] n_eff;
	logic [NW:0] rem_sh;
	logic [efh_pkg::KEY_W-1:0] key;

	assign pa = s_tdata[23:0];
	assign pb = s_tdata[47:24];
	assign key = {mat_q, hi_q, lo_q};
	assign h_sum = pm_q + pl_q + ph_q;
	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == efh_pkg::S_IDLE) && !clr_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = {2'b00, res_st_q, res_idx_q};

	always_comb begin
		if (nb_q == 13'd0) begin
			n_eff = NW'(1);
		end else if (32'(nb_q) > BUCKETS) begin
			n_eff = NW'(BUCKETS);
		end else begin
			n_eff = NW'(nb_q);
		end
		rem_sh = {rem_q[NW-1:0], mag_q[5'(31 - bit_q)]};
	end

	// memories: one write port and one read port each, registered reads
	always_ff @(posedge clk) begin
		if (clr_q) begin
			heads_mem[clr_idx_q] <= NIL;
		end else if (state_q == efh_pkg::S_INS && used_q != POOL_FULL) begin
			heads_mem[bkt_q] <= LW'(used_q);
		end
		head_rd_q <= heads_mem[bkt_q];
		if (state_q == efh_pkg::S_INS && used_q != POOL_FULL) begin
			keys_mem[PW'(used_q)] <= key;
			links_mem[PW'(used_q)] <= head_rd_q;
		end
		key_rd_q <= keys_mem[cur_q[PW-1:0]];
		link_rd_q <= links_mem[cur_q[PW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efh_pkg::S_IDLE;
			nb_q <= efh_pkg::NB_RESET;
			used_q <= '0;
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				nb_q <= cfg_data[12:0];
			end
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + BW'(1);
				if (32'(clr_idx_q) == BUCKETS - 1) begin
					clr_q <= 1'b0;
				end
			end
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				efh_pkg::S_IDLE: begin
					if (s_tvalid && s_tready) begin
						lo_q <= (pb < pa) ? pb : pa;
						hi_q <= (pb < pa) ? pa : pb;
						mat_q <= s_tdata[55:48];
						state_q <= efh_pkg::S_MUL;
					end
				end
				efh_pkg::S_MUL: begin
					pm_q <= 32'(mat_q) * efh_pkg::K_MAT;
					pl_q <= 32'(lo_q) * efh_pkg::K_LO;
					ph_q <= 32'(hi_q) * efh_pkg::K_HI;
					state_q <= efh_pkg::S_SUM;
				end
				efh_pkg::S_SUM: begin
					neg_q <= h_sum[31];
					mag_q <= h_sum[31] ? (~h_sum + 32'd1) : h_sum;
					n_q <= n_eff;
					rem_q <= '0;
					bit_q <= '0;
					state_q <= efh_pkg::S_DIV;
				end
				efh_pkg::S_DIV: begin
					// restoring remainder, one bit per cycle
					if (rem_sh >= (NW+1)'(n_q)) begin
						rem_q <= rem_sh - (NW+1)'(n_q);
					end else begin
						rem_q <= rem_sh;
					end
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd31) begin
						state_q <= efh_pkg::S_HEAD;
					end
				end
				efh_pkg::S_HEAD: begin
					if (neg_q && rem_q != '0) begin
						bkt_q <= BW'((NW+1)'(n_q) - rem_q);
					end else begin
						bkt_q <= BW'(rem_q);
					end
					steps_q <= '0;
					state_q <= efh_pkg::S_WAIT;
				end
				efh_pkg::S_WAIT: begin
					// wait for the head read, then take the chain head
					if (bit_q[0]) begin
						bit_q[0] <= 1'b0;
						cur_q <= head_rd_q;
						state_q <= efh_pkg::S_CMP;
					end else begin
						bit_q[0] <= 1'b1;
					end
				end
				efh_pkg::S_CMP: begin
					if (cur_q == NIL || 32'(cur_q) >= POOL_ENTRIES
							|| steps_q > (CW+1)'(used_q)) begin
						state_q <= efh_pkg::S_INS;
					end else if (state_q == efh_pkg::S_CMP && bit_q[0]) begin
						bit_q[0] <= 1'b0;
						if (key_rd_q == key) begin
							out_idx_q <= efh_pkg::IDX_W'(cur_q);
							out_st_q <= efh_pkg::ST_FOUND;
							state_q <= efh_pkg::S_OUT;
						end else begin
							cur_q <= link_rd_q;
							steps_q <= steps_q + (CW+1)'(1);
						end
					end else begin
						bit_q[0] <= 1'b1; // wait for entry read
					end
				end
				efh_pkg::S_INS: begin
					if (used_q == POOL_FULL) begin
						out_idx_q <= '0;
						out_st_q <= efh_pkg::ST_FULL;
					end else begin
						out_idx_q <= efh_pkg::IDX_W'(used_q);
						out_st_q <= efh_pkg::ST_INSERTED;
						used_q <= used_q + CW'(1);
					end
					state_q <= efh_pkg::S_OUT;
				end
				efh_pkg::S_OUT: begin
					// hold until the result register is free
					if (!out_v_q) begin
						res_idx_q <= out_idx_q;
						res_st_q <= out_st_q;
						out_v_q <= 1'b1;
						state_q <= efh_pkg::S_IDLE;
					end
				end
				default: state_q <= efh_pkg::S_IDLE;
			endcase
		end
	end
endmodule

@@ verif/efh_checker.sv @@
`timescale 1ns / 1ps
module efh_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	output int          mismatch_count,
	output int          pending_count
);
	localparam int unsigned NBK = efh_pkg::BUCKETS_DEF;
	localparam int unsigned NPOOL = efh_pkg::POOL_DEF;
	localparam int unsigned AW = $clog2(NBK);
	localparam int unsigned PAW = $clog2(NPOOL);
	localparam logic [31:0] EMPTY = 32'hFFFF_FFFF;

	logic [12:0] modulus;
	logic [31:0] heads [NBK];
	logic [efh_pkg::KEY_W-1:0] keys [NPOOL];
	logic [31:0] links [NPOOL];
	logic [31:0] used;
	logic [15:0] expected_words [16];
	logic [3:0] wr_ptr;
	logic [3:0] rd_ptr;
	logic [3:0] fill;

	function automatic logic [31:0] bucket_for(logic [23:0] lo, logic [23:0] hi,
			logic [7:0] mat);
		logic [31:0] h;
		logic [31:0] n;
		logic [31:0] r;
		n = 32'(modulus);
		if (n == 0) n = 1;
		if (n > NBK) n = NBK;
		h = 32'(mat) * efh_pkg::K_MAT + 32'(lo) * efh_pkg::K_LO
			+ 32'(hi) * efh_pkg::K_HI;
		if (h[31]) begin
			r = (~h + 32'd1) % n;
			return (r == 0) ? 32'd0 : n - r;
		end
		return h % n;
	endfunction

	// walk the chain, insert on a miss, and return the result word
	function automatic logic [15:0] find_or_insert(logic [55:0] word);
		logic [23:0] a;
		logic [23:0] b;
		logic [23:0] lo;
		logic [23:0] hi;
		logic [7:0] mat;
		logic [efh_pkg::KEY_W-1:0] key;
		logic [31:0] bkt;
		logic [31:0] cur;
		logic [31:0] steps;
		a = word[23:0];
		b = word[47:24];
		mat = word[55:48];
		lo = (b < a) ? b : a;
		hi = (b < a) ? a : b;
		key = {mat, hi, lo};
		bkt = bucket_for(lo, hi, mat);
		cur = heads[bkt[AW-1:0]];
		steps = 0;
		while (cur != EMPTY && cur < NPOOL && steps <= used) begin
			if (keys[cur[PAW-1:0]] == key)
				return {2'd0, efh_pkg::ST_FOUND, cur[efh_pkg::IDX_W-1:0]};
			cur = links[cur[PAW-1:0]];
			steps++;
		end
		if (used >= NPOOL) return {2'd0, efh_pkg::ST_FULL, 12'd0};
		cur = used;
		used++;
		keys[cur[PAW-1:0]] = key;
		links[cur[PAW-1:0]] = heads[bkt[AW-1:0]];
		heads[bkt[AW-1:0]] = cur;
		return {2'd0, efh_pkg::ST_INSERTED, cur[efh_pkg::IDX_W-1:0]};
	endfunction

	assign fill = wr_ptr - rd_ptr;
	assign pending_count = int'(fill);

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			modulus = efh_pkg::NB_RESET;
			for (int i = 0; i < NBK; i++) heads[i] = EMPTY;
			for (int i = 0; i < NPOOL; i++) links[i] = EMPTY;
			used = 0;
			mismatch_count = 0;
			wr_ptr = '0;
			rd_ptr = '0;
		end else begin
			if (cfg_valid && cfg_ready) modulus = cfg_data[12:0];
			if (s_tvalid && s_tready) begin
				expected_words[wr_ptr] = find_or_insert(s_tdata);
				wr_ptr = wr_ptr + 4'd1;
			end
			if (m_tvalid && m_tready) begin
				if (wr_ptr == rd_ptr) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result word %h", m_tdata);
				end else begin
					want = expected_words[rd_ptr];
					rd_ptr = rd_ptr + 4'd1;
					if (m_tdata[11:0] !== want[11:0]
							|| m_tdata[13:12] !== want[13:12]) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result mismatch: expected idx %0d st %0d, got idx %0d st %0d",
								want[11:0], want[13:12], m_tdata[11:0], m_tdata[13:12]);
					end
				end
			end
		end
	end
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	localparam int unsigned CYCLE_LIMIT = 5_000_000;
	localparam int unsigned DRAIN_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;    // num_buckets [12:0]
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;     // point_a [23:0], point_b [47:24], material [55:48]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;     // entry_index [11:0], status [13:12]
	int          mismatch_count;
	int          pending_count;
	int          cycle_count = 0;
	bit          hold_sink;   // set by the stimulus to request a long back-pressure stretch
	bit          sink_quiet;  // turn off random stalls

	// pool of recent edges, reused to provoke hits
	logic [55:0] seen_edges [64];
	int          seen_count = 0;

	edge_find_or_insert_hash dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	efh_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.mismatch_count(mismatch_count), .pending_count(pending_count)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: abandon the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// short gaps mostly, the odd long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int g;
		bit hold_done;
		hold_done = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			g = sink_quiet ? 0 : gap_len();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// present one word and hold it until accepted
	task automatic send_edge(logic [23:0] pa, logic [23:0] pb, logic [7:0] mat);
		int g;
		g = gap_len();
		repeat (g + 1) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {mat, pb, pa};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid <= 1'b0;
		if (seen_count < 64) begin
			seen_edges[seen_count] = {mat, pb, pa};
			seen_count++;
		end else begin
			seen_edges[$urandom_range(0, 63)] = {mat, pb, pa};
		end
	endtask

	task automatic drain();
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_buckets(logic [12:0] nb);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= {3'd0, nb};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random(int count, bit narrow);
		logic [55:0] w;
		for (int i = 0; i < count; i++) begin
			if (seen_count > 0 && $urandom_range(0, 99) < 35) begin
				// reuse a known edge, sometimes with endpoints swapped
				w = seen_edges[$urandom_range(0, seen_count - 1)];
				if ($urandom_range(0, 1)) send_edge(w[47:24], w[23:0], w[55:48]);
				else send_edge(w[23:0], w[47:24], w[55:48]);
			end else if (narrow) begin
				send_edge(24'($urandom_range(0, 15)), 24'($urandom_range(0, 15)),
					8'($urandom_range(0, 3)));
			end else begin
				send_edge(24'($urandom), 24'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		hold_sink = 1'b0;
		sink_quiet = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, hits with swapped endpoints, equal endpoints
		send_edge(24'd0, 24'd0, 8'd0);
		send_edge(24'hFFFFFF, 24'hFFFFFF, 8'hFF);
		send_edge(24'hFFFFFF, 24'd0, 8'd0);
		send_edge(24'd0, 24'hFFFFFF, 8'd0);
		send_edge(24'd0, 24'd0, 8'd0);
		send_edge(24'h123456, 24'h000001, 8'h80);
		send_edge(24'h000001, 24'h123456, 8'h80);
		send_edge(24'hAAAAAA, 24'h555555, 8'h55);
		send_edge(24'h555555, 24'hAAAAAA, 8'hAA);

		// one bucket only, then zero (treated as one) and above range (saturated)
		write_buckets(13'd1);
		send_edge(24'd0, 24'd0, 8'd0);
		send_edge(24'd7, 24'd9, 8'd3);
		send_edge(24'd9, 24'd7, 8'd3);
		write_buckets(13'd0);
		send_edge(24'd7, 24'd9, 8'd3);
		send_edge(24'hFFFFFF, 24'd1, 8'd1);
		write_buckets(13'h1FFF);
		send_edge(24'hFFFFFF, 24'hFFFFFF, 8'hFF);
		send_edge(24'd3, 24'd4, 8'd5);
		write_buckets(13'd4096);
		send_edge(24'd3, 24'd4, 8'd5);

		// long receiver hold-off while the sender keeps offering
		hold_sink = 1'b1;
		send_random(20, 1'b0);

		write_buckets(13'd7);
		send_random(120, 1'b1);
		write_buckets(13'd4095);
		send_random(150, 1'b0);
		write_buckets(13'd1);
		send_random(40, 1'b1);
		write_buckets(13'd4096);
		sink_quiet = 1'b1;
		send_random(120, 1'b0);
		sink_quiet = 1'b0;
		write_buckets(13'd300);
		send_random(100, 1'b0);

		drain();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

@@ sim.f @@
rtl/core/efh_pkg.sv
rtl/core/edge_find_or_insert_hash.sv
verif/efh_checker.sv
verif/tb_top.sv
